// File: hw/rtl/pds_pkg.sv
// Package for the PDM clock divider search: request and result types,
// field widths, ratio and PLL tables, divider split function.
// No dependencies.
package pds_pkg;

    localparam int unsigned PCM_W      = 18;
    localparam int unsigned CLK_W      = 26;
    localparam int unsigned PLL_W      = 32;
    localparam int unsigned RATIO_W    = 8;
    localparam int unsigned DEC_W      = 7;
    localparam int unsigned D1_W       = 2;
    localparam int unsigned D2_W       = 4;
    localparam int unsigned MASK_W     = 6;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned NUM_RATIOS = 7;
    localparam int unsigned NUM_PLL    = 6;
    localparam int unsigned KHZ_TO_HZ  = 1000;
    localparam int unsigned D1_MIN     = 2;
    localparam int unsigned D1_MAX     = 4;
    localparam int unsigned D2_MIN     = 2;
    localparam int unsigned D2_MAX     = 16;
    // total division d1*d2 never exceeds 64, so 7 quotient bits matter
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned MUL_STEPS  = RATIO_W;
    localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int unsigned DIV_STEPS  = PLL_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [MASK_W-1:0] MASK_RESET = 6'h3F;

    typedef struct packed {
        logic [PCM_W-1:0] sample_rate_hz;
        logic [CLK_W-1:0] min_clock_hz;
        logic [CLK_W-1:0] max_clock_hz;
        logic [PLL_W-1:0] pll_preset_hz;
    } pds_req_t;

    typedef struct packed {
        logic               found;
        logic [RATIO_W-1:0] oversample_ratio;
        logic [DEC_W-1:0]   decimation_rate;
        logic [D1_W-1:0]    clock_div_code;
        logic [D2_W-1:0]    dma_clock_div_code;
        logic [CLK_W-1:0]   pll_program_hz;
    } pds_res_t;

    typedef struct packed {
        logic               start;
        logic [PCM_W-1:0]   rate;
        logic [RATIO_W-1:0] ratio;
    } pds_mul_req_t;

    typedef struct packed {
        logic             done;
        logic [CLK_W-1:0] product;
    } pds_mul_stat_t;

    typedef struct packed {
        logic             start;
        logic [PLL_W-1:0] dividend;
        logic [CLK_W-1:0] divisor;
    } pds_div_req_t;

    typedef struct packed {
        logic             done;
        logic [PLL_W-1:0] quot;
        logic             rem_zero;
    } pds_div_stat_t;

    typedef struct packed {
        logic            ok;
        logic [D1_W-1:0] d1_code;
        logic [D2_W-1:0] d2_code;
    } pds_split_t;

    function automatic logic [RATIO_W-1:0] ratio_at(logic [IDX_W-1:0] idx);
        logic [RATIO_W-1:0] r;
        case (idx)
            3'd0:    r = 8'd64;
            3'd1:    r = 8'd96;
            3'd2:    r = 8'd100;
            3'd3:    r = 8'd48;
            3'd4:    r = 8'd50;
            3'd5:    r = 8'd32;
            3'd6:    r = 8'd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [CLK_W-1:0] pll_hz_at(logic [IDX_W-1:0] idx);
        logic [CLK_W-1:0] f;
        case (idx)
            3'd0:    f = CLK_W'(12288 * KHZ_TO_HZ);
            3'd1:    f = CLK_W'(16384 * KHZ_TO_HZ);
            3'd2:    f = CLK_W'(24000 * KHZ_TO_HZ);
            3'd3:    f = CLK_W'(24576 * KHZ_TO_HZ);
            3'd4:    f = CLK_W'(27648 * KHZ_TO_HZ);
            3'd5:    f = CLK_W'(48000 * KHZ_TO_HZ);
            default: f = '0;
        endcase
        return f;
    endfunction

    // Splits total = d1*d2; smallest d1 wins (scanned last).
    function automatic pds_split_t split_total(logic [TOTAL_W-1:0] total);
        pds_split_t s;
        s = '0;
        for (int a = D1_MAX; a >= D1_MIN; a--) begin
            for (int b = D2_MIN; b <= D2_MAX; b++) begin
                if (total == TOTAL_W'(a * b)) begin
                    s.ok      = 1'b1;
                    s.d1_code = D1_W'(a - 1);
                    s.d2_code = D2_W'(b - 1);
                end
            end
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/pds_mul_serial.sv
// Bit-serial shift-and-add multiplier: io clock = pcm rate * ratio.
// Depends on pds_pkg.
module pds_mul_serial
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pds_pkg::pds_mul_req_t  req,
    output pds_pkg::pds_mul_stat_t stat
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [pds_pkg::MUL_CNT_W-1:0]  cnt_reg;
    logic [pds_pkg::CLK_W-1:0]      acc_reg;
    logic [pds_pkg::CLK_W-1:0]      mcand_reg;
    logic [pds_pkg::RATIO_W-1:0]    mplier_reg;
    logic [pds_pkg::CLK_W-1:0]      acc_next;

    assign acc_next = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pds_pkg::MUL_CNT_W'(pds_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= pds_pkg::CLK_W'(req.rate);
            mplier_reg <= req.ratio;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[pds_pkg::CLK_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[pds_pkg::RATIO_W-1:1]};
        end
    end

    assign stat.done    = done_reg;
    assign stat.product = acc_reg;

endmodule

// File: hw/rtl/pds_div_serial.sv
// Restoring divider, one quotient bit per cycle: PLL frequency / io clock.
// Depends on pds_pkg.
module pds_div_serial
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pds_pkg::pds_div_req_t  req,
    output pds_pkg::pds_div_stat_t stat
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [pds_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [pds_pkg::PLL_W-1:0]      quot_reg;
    logic [pds_pkg::CLK_W-1:0]      rem_reg;
    logic [pds_pkg::CLK_W-1:0]      dvs_reg;
    logic [pds_pkg::CLK_W:0]        trial;
    logic [pds_pkg::CLK_W+1:0]      diff;
    logic                           take;

    assign trial = {rem_reg, quot_reg[pds_pkg::PLL_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign take  = !diff[pds_pkg::CLK_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pds_pkg::DIV_CNT_W'(pds_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so 26 bits hold it
            rem_reg  <= take ? diff[pds_pkg::CLK_W-1:0] : trial[pds_pkg::CLK_W-1:0];
            quot_reg <= {quot_reg[pds_pkg::PLL_W-2:0], take};
        end
    end

    assign stat.done     = done_reg;
    assign stat.quot     = quot_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

// File: hw/rtl/pdm_clock_divider_search.sv
// Top level of the PDM clock divider search: sequencer, mask register,
// result register. Depends on pds_pkg, pds_mul_serial, pds_div_serial.
//
// One request at a time. For each oversampling ratio (64, 96, 100, 48, 50,
// 32, 128) a bit-serial multiplier forms the io clock in 8 steps and the
// window check follows; each PLL candidate then costs one pass of the
// bit-serial divider, 32 steps. With a preset PLL frequency only the preset
// is tried for each ratio, else the PLL table; a hit ends the search early,
// and table entries masked off in mask_reg skip their division. req_ready
// is high only in the idle state, also while a result still waits in the
// output register. cfg_we writes the mask; write it only between
// requests.
module pdm_clock_divider_search
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  pds_pkg::pds_req_t           req_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pds_pkg::pds_res_t           res_data,
    input  logic                        cfg_we,
    input  logic [pds_pkg::MASK_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WIN,
        ST_SEL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    pds_pkg::pds_req_t             item_reg;
    logic [pds_pkg::MASK_W-1:0]    mask_reg;
    logic [pds_pkg::IDX_W-1:0]     r_idx_reg;
    logic [pds_pkg::IDX_W-1:0]     f_idx_reg;
    logic [pds_pkg::CLK_W-1:0]     io_reg;
    logic [pds_pkg::PLL_W-1:0]     dividend_reg;
    logic                          mul_start_reg;
    logic                          div_start_reg;
    pds_pkg::pds_res_t             pend_reg;
    pds_pkg::pds_res_t             res_reg;
    logic                          res_valid_reg;

    pds_pkg::pds_mul_req_t         mul_req;
    pds_pkg::pds_mul_stat_t        mul_stat;
    pds_pkg::pds_div_req_t         div_req;
    pds_pkg::pds_div_stat_t        div_stat;
    pds_pkg::pds_split_t           split;
    pds_pkg::pds_res_t             hit_res;
    logic                          preset_on;
    logic                          last_ratio;
    logic                          last_freq;
    logic                          outside;
    logic                          div_ok;
    logic                          sel_div;
    logic                          ratio_end;
    logic                          mul_start_next;
    logic                          div_start_next;
    logic                          res_load;

    // ---- serial arithmetic units ----
    assign mul_req.start = mul_start_reg;
    assign mul_req.rate  = item_reg.sample_rate_hz;
    assign mul_req.ratio = pds_pkg::ratio_at(r_idx_reg);

    pds_mul_serial u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = io_reg;

    pds_div_serial u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // ---- trial evaluation ----
    assign preset_on  = (item_reg.pll_preset_hz != '0);
    assign last_ratio = (r_idx_reg == pds_pkg::IDX_W'(pds_pkg::NUM_RATIOS - 1));
    assign last_freq  = (f_idx_reg == pds_pkg::IDX_W'(pds_pkg::NUM_PLL - 1));
    // zero io clock never divides, so it counts as outside the window
    assign outside    = (io_reg == '0) || (io_reg < item_reg.min_clock_hz)
                        || (io_reg > item_reg.max_clock_hz);
    assign split      = pds_pkg::split_total(div_stat.quot[pds_pkg::TOTAL_W-1:0]);
    // exact division, quotient small enough, and a d1*d2 split exists
    assign div_ok     = div_stat.rem_zero
                        && (div_stat.quot[pds_pkg::PLL_W-1:pds_pkg::TOTAL_W] == '0)
                        && split.ok;

    always_comb
    begin
        hit_res                    = '0;
        hit_res.found              = 1'b1;
        hit_res.oversample_ratio   = pds_pkg::ratio_at(r_idx_reg);
        hit_res.decimation_rate    =
            hit_res.oversample_ratio[pds_pkg::RATIO_W-1:1];
        hit_res.clock_div_code     = split.d1_code;
        hit_res.dma_clock_div_code = split.d2_code;
        hit_res.pll_program_hz     = preset_on ? '0 : pds_pkg::pll_hz_at(f_idx_reg);
    end

    // ---- start pulses for the serial units ----
    // a division starts from ST_SEL on the preset or an accepted table entry
    assign sel_div = preset_on || mask_reg[f_idx_reg];

    // all candidates of the current ratio are used up at this edge
    always_comb
    begin
        case (state_reg)
            ST_WIN:  ratio_end = outside;
            ST_SEL:  ratio_end = !sel_div && last_freq;
            ST_DIV:  ratio_end = div_stat.done && !div_ok && (preset_on || last_freq);
            default: ratio_end = 1'b0;
        endcase
    end

    assign mul_start_next = ((state_reg == ST_IDLE) && req_valid)
                            || (ratio_end && !last_ratio);
    assign div_start_next = (state_reg == ST_SEL) && sel_div;

    // pending result moves to the output register once it is free
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);

    // ---- mask register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= pds_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            r_idx_reg     <= '0;
            f_idx_reg     <= '0;
            io_reg        <= '0;
            dividend_reg  <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            pend_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg  <= req_data;
                        r_idx_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        io_reg    <= mul_stat.product;
                        state_reg <= ST_WIN;
                    end
                end

                ST_WIN:
                begin
                    if (!outside)
                    begin
                        f_idx_reg <= '0;
                        state_reg <= ST_SEL;
                    end
                    else if (last_ratio)
                    begin
                        pend_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        r_idx_reg <= r_idx_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end

                ST_SEL:
                begin
                    if (preset_on)
                    begin
                        dividend_reg <= item_reg.pll_preset_hz;
                        state_reg    <= ST_DIV;
                    end
                    else if (mask_reg[f_idx_reg])
                    begin
                        dividend_reg <= pds_pkg::PLL_W'(pds_pkg::pll_hz_at(f_idx_reg));
                        state_reg    <= ST_DIV;
                    end
                    else if (!last_freq)
                    begin
                        f_idx_reg <= f_idx_reg + 1'b1;
                    end
                    else if (last_ratio)
                    begin
                        pend_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        r_idx_reg <= r_idx_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_ok)
                        begin
                            pend_reg  <= hit_res;
                            state_reg <= ST_DONE;
                        end
                        else if (!preset_on && !last_freq)
                        begin
                            f_idx_reg <= f_idx_reg + 1'b1;
                            state_reg <= ST_SEL;
                        end
                        else if (last_ratio)
                        begin
                            pend_reg  <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            r_idx_reg <= r_idx_reg + 1'b1;
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_DONE:
                begin
                    // hand over once the output register is free
                    if (res_load)
                    begin
                        res_reg   <= pend_reg;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.found) |->
        (res_data.oversample_ratio == '0 && res_data.decimation_rate == '0
         && res_data.clock_div_code == '0 && res_data.dma_clock_div_code == '0
         && res_data.pll_program_hz == '0))
        else $error("miss result with nonzero fields");

    // a hit has legal divider codes and a consistent decimation rate
    a_hit_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.found) |->
        (res_data.clock_div_code != '0 && res_data.dma_clock_div_code != '0
         && res_data.decimation_rate == res_data.oversample_ratio[7:1]))
        else $error("hit result with bad codes");

    // an accepted request starts the multiplier in the next cycle
    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (mul_start_reg && !req_ready))
        else $error("request accepted without starting the search");
`endif

endmodule
